// ----- hw/rtl/arpf_pkg.sv -----
// Package for the ARP reply spoof filter: transaction structs, request codes,
// frame byte offsets and protocol constants. No dependencies.
package arpf_pkg;

    // Default depth of the trusted binding table
    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    // Request codes carried in req_type
    localparam logic REQ_FRAME_BYTE  = 1'b0;
    localparam logic REQ_TABLE_WRITE = 1'b1;

    // Protocol constants
    localparam logic [15:0] ETHERTYPE_ARP    = 16'h0806;
    localparam logic [15:0] ARP_OPCODE_REPLY = 16'h0002;

    // Byte offsets within the frame (bytes counted from zero)
    localparam logic [5:0] POS_ETYPE_HI    = 6'd12;
    localparam logic [5:0] POS_ETYPE_LO    = 6'd13;
    localparam logic [5:0] POS_OPCODE_HI   = 6'd20;
    localparam logic [5:0] POS_OPCODE_LO   = 6'd21;
    localparam logic [5:0] POS_SMAC_FIRST  = 6'd22;
    localparam logic [5:0] POS_SMAC_LAST   = 6'd27;
    localparam logic [5:0] POS_SIP_FIRST   = 6'd28;
    localparam logic [5:0] POS_SIP_LAST    = 6'd31;
    localparam logic [5:0] MIN_FRAME_BYTES = 6'd42;

    // Input transaction
    typedef struct packed {
        logic        req_type;
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic [31:0] entry_ip;
        logic [47:0] entry_mac;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic        verdict;
        logic [63:0] drop_total;
    } t_out_item;

    // Table write request from the top level to the binding table
    typedef struct packed {
        logic        en;
        logic [3:0]  index;
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_tbl_wr;

endpackage

// ----- hw/rtl/arpf_table.sv -----
// Trusted IP/MAC binding table with a parallel lookup port.
// Depends on arpf_pkg.
module arpf_table import arpf_pkg::*; #(
    parameter int unsigned Entries = TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tbl_wr            i_wr,
    input  logic [31:0]        i_look_ip,
    input  logic [47:0]        i_look_mac,
    output logic [Entries-1:0] o_hit,
    output logic [Entries-1:0] o_mis
);

    logic [Entries-1:0] r_valid;
    logic [31:0]        r_ip  [Entries];
    logic [47:0]        r_mac [Entries];

    for (genvar g = 0; g < Entries; g++) begin : g_entry
        localparam logic [8:0] SlotIdx = 9'(g);
        logic sel;

        assign sel = i_wr.en && ({5'b0, i_wr.index} == SlotIdx);

        // Enable or remove the slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (sel) begin
                r_valid[g] <= i_wr.valid;
            end
        end

        // Store the binding
        always_ff @(posedge i_clk) begin
            if (sel) begin
                r_ip[g]  <= i_wr.ip;
                r_mac[g] <= i_wr.mac;
            end
        end

        // Compare against the captured sender fields
        assign o_hit[g] = r_valid[g] && (r_ip[g] == i_look_ip);
        assign o_mis[g] = (r_mac[g] != i_look_mac);
    end

endmodule

// ----- hw/rtl/arp_reply_spoof_filter_top.sv -----
// ARP reply spoof filter top level: byte parser, verdict pipeline, output skid.
// Depends on arpf_pkg and arpf_table.
//
// Usage: the input channel (i_valid, o_stall, i_item) carries one transaction
// per cycle, either one frame byte with its end-of-frame mark or one write to
// the trusted IP/MAC table. The output channel (o_valid, i_stall, o_item)
// carries one verdict per frame, at its last byte, with the running count of
// dropped frames. Table writes and bytes without the end mark give nothing.
// Throughput: one transaction per cycle, sustained, as long as results are
// taken. A verdict reaches o_item through the input register, the parse and
// table compare register, the lowest match select register and the counter
// update into the output register, in that order, once its last byte is accepted.
// Stall: a waiting result sits in the output register and the pipeline keeps
// running; a second result goes into a one-entry skid register, and only
// while the skid is full is o_stall high and the whole pipeline frozen.
// Reset (i_rst_n low at a clock edge): frame state, drop count and table
// valid marks clear; the pipeline, output and skid empty; o_stall falls.
module arp_reply_spoof_filter_top import arpf_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic en;
    logic accept;

    // Input register
    logic     r_a_vld;
    t_in_item r_a;

    // Per-frame parse state
    logic [5:0]  r_pos,  n_pos;
    logic        r_arp,  n_arp;
    logic        r_rply, n_rply;
    logic [7:0]  r_hdr,  n_hdr;
    logic [47:0] r_smac, n_smac;
    logic [31:0] r_sip,  n_sip;

    // Compare and select stages
    logic                     r_c_vld;
    logic                     r_c_ok;
    logic [TABLE_ENTRIES-1:0] r_c_hit;
    logic [TABLE_ENTRIES-1:0] r_c_mis;
    logic                     r_d_vld;
    logic                     r_d_drop;

    // Counter, output and skid
    logic [63:0] r_cnt;
    logic        r_out_vld;
    t_out_item   r_out;
    logic        r_skid_vld;
    t_out_item   r_skid;

    logic                     b_byte;
    logic                     b_end;
    logic                     frame_ok;
    t_tbl_wr                  tbl_wr;
    logic [TABLE_ENTRIES-1:0] hit;
    logic [TABLE_ENTRIES-1:0] mis;
    logic [TABLE_ENTRIES-1:0] first_hit;
    logic                     drop;
    logic                     produce;
    logic                     take;
    t_out_item                res;

    // Advance the pipeline unless the skid holds a result
    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;
    assign accept  = i_valid && en;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= i_item;
        end
    end

    assign b_byte = en && r_a_vld && (r_a.req_type == REQ_FRAME_BYTE);
    assign b_end  = b_byte && r_a.frame_end;

    // Route table writes
    always_comb begin
        tbl_wr.en    = en && r_a_vld && (r_a.req_type == REQ_TABLE_WRITE);
        tbl_wr.index = r_a.entry_index;
        tbl_wr.valid = r_a.entry_valid;
        tbl_wr.ip    = r_a.entry_ip;
        tbl_wr.mac   = r_a.entry_mac;
    end

    arpf_table #(
        .Entries    (TABLE_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_look_ip  (r_sip),
        .i_look_mac (r_smac),
        .o_hit      (hit),
        .o_mis      (mis)
    );

    // Parse one frame byte; clear the frame state at its end
    always_comb begin
        n_pos  = r_pos;
        n_arp  = r_arp;
        n_rply = r_rply;
        n_hdr  = r_hdr;
        n_smac = r_smac;
        n_sip  = r_sip;
        if (b_byte) begin
            if (r_pos < MIN_FRAME_BYTES) begin
                if (r_pos == POS_ETYPE_HI || r_pos == POS_OPCODE_HI) begin
                    n_hdr = r_a.frame_byte;
                end else if (r_pos == POS_ETYPE_LO) begin
                    n_arp = ({r_hdr, r_a.frame_byte} == ETHERTYPE_ARP);
                end else if (r_pos == POS_OPCODE_LO) begin
                    n_rply = ({r_hdr, r_a.frame_byte} == ARP_OPCODE_REPLY);
                end else if (r_pos >= POS_SMAC_FIRST && r_pos <= POS_SMAC_LAST) begin
                    n_smac = {r_smac[39:0], r_a.frame_byte};
                end else if (r_pos >= POS_SIP_FIRST && r_pos <= POS_SIP_LAST) begin
                    n_sip = {r_sip[23:0], r_a.frame_byte};
                end
                n_pos = r_pos + 6'd1;
            end
            if (r_a.frame_end) begin
                n_pos  = '0;
                n_arp  = 1'b0;
                n_rply = 1'b0;
                n_hdr  = '0;
                n_smac = '0;
                n_sip  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_arp  <= 1'b0;
            r_rply <= 1'b0;
            r_hdr  <= '0;
            r_smac <= '0;
            r_sip  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_arp  <= n_arp;
            r_rply <= n_rply;
            r_hdr  <= n_hdr;
            r_smac <= n_smac;
            r_sip  <= n_sip;
        end
    end

    // The last byte reaches the minimum length only from the 42nd position on;
    // bytes from there on never touch the captured fields
    assign frame_ok = (r_pos >= (MIN_FRAME_BYTES - 6'd1)) && r_arp && r_rply;

    // Register the compare vectors at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= b_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_end) begin
            r_c_ok  <= frame_ok;
            r_c_hit <= hit;
            r_c_mis <= mis;
        end
    end

    // Pick the lowest matching entry and decide
    assign first_hit = r_c_hit & (-r_c_hit);
    assign drop      = r_c_ok && |(first_hit & r_c_mis);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_c_vld) begin
            r_d_drop <= drop;
        end
    end

    // Count drops and form the result
    assign produce        = en && r_d_vld;
    assign res.verdict    = r_d_drop;
    assign res.drop_total = r_cnt + 64'(r_d_drop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (produce) begin
            r_cnt <= res.drop_total;
        end
    end

    // Hold results in the output register, spill to the skid when stalled
    assign take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (produce) begin
            if (r_out_vld && !take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (produce) begin
            if (r_out_vld && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

// ----- hw/rtl/arpf_checker.sv -----
// Port-level checker for the ARP reply spoof filter, bound to the top level.
// Depends on arpf_pkg and arp_reply_spoof_filter_top.
module arpf_checker import arpf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // Reset empties the output side and releases the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_stall && !o_valid))
        else $error("output or stall not cleared after reset");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result withdrawn while stalled");

    // A stalled result does not change
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_item))
        else $error("result changed while stalled");

    // The input stalls only behind a full output register
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // Stall begins only after a result was refused
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without a refused result");

endmodule

bind arp_reply_spoof_filter_top arpf_checker u_arpf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// ----- tb/arp_reply_spoof_filter_top_tb.sv -----
// Self-checking testbench for arp_reply_spoof_filter_top: drives frame bytes and trusted-table
// writes, predicts each frame verdict and drop count, and checks them in order.
// Depends on arpf_pkg and the filter RTL.
`timescale 1ns / 100ps

module arp_reply_spoof_filter_top_tb;
    import arpf_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned TARGET_ITEMS  = 1100;

    localparam logic [31:0] IP_A   = 32'hC0A8_0A01;
    localparam logic [31:0] IP_UNK = 32'h0A00_0001;
    localparam logic [47:0] MAC_A  = 48'h0211_2233_4455;
    localparam logic [47:0] MAC_B  = 48'h0211_2233_4456;

    typedef logic [7:0] t_byte_q[$];

    // Verdict predictor and in-order checker
    class arp_verdict_scoreboard;
        logic [31:0] bind_ip    [TABLE_ENTRIES_DEF];
        logic [47:0] bind_mac   [TABLE_ENTRIES_DEF];
        bit          bind_valid [TABLE_ENTRIES_DEF];
        logic [5:0]  byte_pos;
        bit          etype_arp;
        bit          op_reply;
        logic [7:0]  hdr_byte;
        logic [47:0] cap_mac;
        logic [31:0] cap_ip;
        logic [63:0] drop_tally;
        t_out_item   pending_verdicts[$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
                bind_ip[i]    = '0;
                bind_mac[i]   = '0;
                bind_valid[i] = 1'b0;
            end
            drop_tally = '0;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            etype_arp = 1'b0;
            op_reply  = 1'b0;
            hdr_byte  = '0;
            cap_mac   = '0;
            cap_ip    = '0;
        endfunction

        // Advance the frame state by one accepted transaction
        function void predict_verdict(t_in_item it);
            t_out_item want;
            bit        drop;
            bit        found;
            if (it.req_type == REQ_TABLE_WRITE) begin
                bind_valid[it.entry_index] = it.entry_valid;
                bind_ip[it.entry_index]    = it.entry_ip;
                bind_mac[it.entry_index]   = it.entry_mac;
                return;
            end
            // Capture header fields; bytes past the minimum length are dropped
            if (byte_pos < MIN_FRAME_BYTES) begin
                if (byte_pos == POS_ETYPE_HI || byte_pos == POS_OPCODE_HI)
                    hdr_byte = it.frame_byte;
                else if (byte_pos == POS_ETYPE_LO)
                    etype_arp = ({hdr_byte, it.frame_byte} == ETHERTYPE_ARP);
                else if (byte_pos == POS_OPCODE_LO)
                    op_reply = ({hdr_byte, it.frame_byte} == ARP_OPCODE_REPLY);
                else if (byte_pos >= POS_SMAC_FIRST && byte_pos <= POS_SMAC_LAST)
                    cap_mac = {cap_mac[39:0], it.frame_byte};
                else if (byte_pos >= POS_SIP_FIRST && byte_pos <= POS_SIP_LAST)
                    cap_ip = {cap_ip[23:0], it.frame_byte};
                byte_pos = byte_pos + 6'd1;
            end
            if (!it.frame_end)
                return;
            // Judge at frame end: lowest valid index with a matching IP decides
            drop  = 1'b0;
            found = 1'b0;
            if (byte_pos == MIN_FRAME_BYTES && etype_arp && op_reply) begin
                for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
                    if (!found && bind_valid[i] && bind_ip[i] == cap_ip) begin
                        found = 1'b1;
                        drop  = (bind_mac[i] != cap_mac);
                    end
                end
            end
            if (drop)
                drop_tally = drop_tally + 64'd1;
            want.verdict    = drop;
            want.drop_total = drop_tally;
            pending_verdicts.push_back(want);
            clear_frame();
        endfunction

        task log_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one result transaction with the oldest prediction
        task check_verdict(t_out_item got);
            t_out_item want;
            if (pending_verdicts.size() == 0) begin
                log_mismatch($sformatf("unexpected result verdict=%0b drop_total=%0d",
                                       got.verdict, got.drop_total));
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.verdict !== want.verdict)
                log_mismatch($sformatf("verdict got %0b want %0b", got.verdict, want.verdict));
            if (got.drop_total !== want.drop_total)
                log_mismatch($sformatf("drop_total got %0d want %0d",
                                       got.drop_total, want.drop_total));
        endtask
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    arp_verdict_scoreboard sb;
    bit          quiet = 1'b0;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    int          rx_hold     = 0;
    logic [31:0] gen_ip  [TABLE_ENTRIES_DEF];
    logic [47:0] gen_mac [TABLE_ENTRIES_DEF];

    arp_reply_spoof_filter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none while quiet
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [31:0] pool_ip(int k);
        case (k)
            0:       return IP_A;
            1:       return 32'h0000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'hC0A8_0A02;
            4:       return 32'h8000_0001;
            default: return 32'h7F00_0001;
        endcase
    endfunction

    // Frame-byte transaction with random content in the unused fields
    function automatic t_in_item noise_item();
        t_in_item it;
        it.req_type    = REQ_FRAME_BYTE;
        it.frame_byte  = 8'($urandom);
        it.frame_end   = 1'b0;
        it.entry_index = 4'($urandom);
        it.entry_valid = 1'($urandom);
        it.entry_ip    = $urandom;
        it.entry_mac   = rand_mac();
        return it;
    endfunction

    function automatic t_in_item table_item(logic [3:0] idx, logic on,
                                            logic [31:0] ip, logic [47:0] mac);
        t_in_item it;
        it             = noise_item();
        it.req_type    = REQ_TABLE_WRITE;
        it.frame_end   = 1'($urandom);
        it.entry_index = idx;
        it.entry_valid = on;
        it.entry_ip    = ip;
        it.entry_mac   = mac;
        return it;
    endfunction

    function automatic t_in_item rand_table_item();
        logic [31:0] ip;
        int          r;
        r = $urandom_range(0, 3);
        if (r < 2)
            ip = pool_ip($urandom_range(0, 5));
        else if (r == 2)
            ip = gen_ip[$urandom_range(0, TABLE_ENTRIES_DEF - 1)];
        else
            ip = $urandom;
        return table_item(4'($urandom), $urandom_range(0, 4) != 0, ip, rand_mac());
    endfunction

    // Build frame bytes with the given header fields, random elsewhere
    function automatic t_byte_q make_frame(logic [15:0] etype, logic [15:0] opcode,
                                           logic [47:0] smac, logic [31:0] sip, int len);
        t_byte_q fb;
        for (int i = 0; i < len; i++) begin
            logic [7:0] b;
            b = 8'($urandom);
            if (i == POS_ETYPE_HI)
                b = etype[15:8];
            else if (i == POS_ETYPE_LO)
                b = etype[7:0];
            else if (i == POS_OPCODE_HI)
                b = opcode[15:8];
            else if (i == POS_OPCODE_LO)
                b = opcode[7:0];
            else if (i >= POS_SMAC_FIRST && i <= POS_SMAC_LAST)
                b = smac[8 * (POS_SMAC_LAST - i) +: 8];
            else if (i >= POS_SIP_FIRST && i <= POS_SIP_LAST)
                b = sip[8 * (POS_SIP_LAST - i) +: 8];
            fb.push_back(b);
        end
        return fb;
    endfunction

    // Drive one transaction after a random gap and hold it until accepted
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        items_sent++;
        if (it.req_type == REQ_TABLE_WRITE) begin
            gen_ip[it.entry_index]  = it.entry_ip;
            gen_mac[it.entry_index] = it.entry_mac;
        end
    endtask

    // Send a frame, optionally with one extra transaction before byte mid_at
    task automatic send_frame(input t_byte_q fb, input int mid_at, input t_in_item mid);
        t_in_item it;
        foreach (fb[i]) begin
            if (i == mid_at)
                send_item(mid);
            it            = noise_item();
            it.frame_byte = fb[i];
            it.frame_end  = (i == fb.size() - 1);
            send_item(it);
        end
    endtask

    // Random output stalls in runs
    always @(posedge i_clk) begin
        if (!quiet && rx_hold == 0 && $urandom_range(0, 2) == 0)
            rx_hold = pick_gap();
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor both channels: check results first, then predict from inputs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_verdict(o_item);
            if (i_valid && !o_stall)
                sb.predict_verdict(i_item);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("arp_reply_spoof_filter_top regression: fail");
        $finish;
    end

    initial begin
        int          r;
        int          s;
        int          len;
        int          mid_at;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] etype;
        logic [15:0] opcode;
        t_in_item    mid;

        sb = new();
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            gen_ip[i]  = '0;
            gen_mac[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bindings with a duplicate IP, all-ones and all-zero entries
        mid = noise_item();
        send_item(table_item(4'd0, 1'b1, IP_A, MAC_A));
        send_item(table_item(4'd3, 1'b1, IP_A, MAC_B));
        send_item(table_item(4'd15, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        send_item(table_item(4'd7, 1'b1, 32'h0000_0000, 48'h0000_0000_0000));
        // One-byte frame, then a spoofed reply one byte too short
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, MAC_B, IP_A, 1), -1, mid);
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, MAC_B, IP_A, 41), -1, mid);
        // Spoof caught by the lowest index, then a genuine reply
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, MAC_B, IP_A, 42), -1, mid);
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, MAC_A, IP_A, 42), -1, mid);
        // Long frame with bytes past the minimum, all-ones IP, zero MAC
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, 48'h0, 32'hFFFF_FFFF, 64),
                   -1, mid);
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, 48'h0, 32'h0, 42), -1, mid);
        // Request opcode, VLAN-tagged frame, unknown sender IP
        send_frame(make_frame(ETHERTYPE_ARP, 16'h0001, MAC_B, IP_A, 42), -1, mid);
        send_frame(make_frame(16'h8100, ARP_OPCODE_REPLY, MAC_B, IP_A, 46), -1, mid);
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, MAC_B, IP_UNK, 42), -1, mid);
        // Remove slot 0 so the duplicate at slot 3 decides
        send_item(table_item(4'd0, 1'b0, IP_A, MAC_A));
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, MAC_A, IP_A, 42), -1, mid);
        // Restore slot 0 in the middle of a frame
        send_frame(make_frame(ETHERTYPE_ARP, ARP_OPCODE_REPLY, MAC_B, IP_A, 42), 30,
                   table_item(4'd0, 1'b1, IP_A, MAC_A));

        // Random: fill every slot, then mostly well-formed replies
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            send_item(table_item(4'(i), $urandom_range(0, 5) != 0,
                                 (i < 6) ? pool_ip(i) : $urandom, rand_mac()));
        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 29) == 0)
                quiet = !quiet;
            r      = $urandom_range(0, 99);
            mid_at = -1;
            mid    = rand_table_item();
            etype  = ETHERTYPE_ARP;
            opcode = ARP_OPCODE_REPLY;
            s      = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
            ip     = gen_ip[s];
            len    = ($urandom_range(0, 4) != 0) ? $urandom_range(42, 46)
                                                 : $urandom_range(47, 64);
            case ($urandom_range(0, 4))
                0, 1:    mac = gen_mac[s];
                2, 3:    mac = gen_mac[s] ^ (48'd1 << $urandom_range(0, 47));
                default: mac = rand_mac();
            endcase
            if ($urandom_range(0, 15) == 0)
                mid_at = $urandom_range(0, len - 1);
            if (r < 8) begin
                send_item(mid);
            end else if (r < 75) begin
                send_frame(make_frame(etype, opcode, mac, ip, len), mid_at, mid);
            end else if (r < 90) begin
                // Break one condition of an otherwise well-formed reply
                case ($urandom_range(0, 3))
                    0:       etype = etype ^ (16'd1 << $urandom_range(0, 15));
                    1:       opcode = opcode ^ (16'd1 << $urandom_range(0, 15));
                    2:       len = $urandom_range(32, 41);
                    default: etype = 16'h8100;
                endcase
                send_frame(make_frame(etype, opcode, mac, ip, len), mid_at, mid);
            end else begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 20);
                send_frame(make_frame(16'($urandom), 16'($urandom), rand_mac(), $urandom,
                                      len), -1, mid);
            end
        end
        i_valid <= 1'b0;
        quiet = 1'b0;

        // Drain outstanding verdicts, then let the pipeline settle
        while (sb.pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("arp_reply_spoof_filter_top regression: pass");
        else
            $display("arp_reply_spoof_filter_top regression: fail");
        $finish;
    end

endmodule

// ----- arp_reply_spoof_filter_top.f -----
hw/rtl/arpf_pkg.sv
hw/rtl/arpf_table.sv
hw/rtl/arp_reply_spoof_filter_top.sv
hw/rtl/arpf_checker.sv
tb/arp_reply_spoof_filter_top_tb.sv
